// ----- rtl/abuc_pkg.sv -----
// shared types, codes and the crc-32 byte step for the a/b bank update controller
// used by ab_bank_update_controller; no dependencies
package abuc_pkg;

    // bank size in bytes and the width of a byte counter that can hold it
    localparam int BANK_BYTES = 262144;
    localparam int CNT_W      = $clog2(BANK_BYTES + 1);

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] VER_INIT = 32'h00010000;

    localparam logic [3:0] TRIES_MAX = 4'd15;

    // configuration register indexes
    localparam logic CFG_HW_REVISION  = 1'b0;
    localparam logic CFG_MAX_ATTEMPTS = 1'b1;

    // commands
    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_DATA     = 3'd1;
    localparam logic [2:0] CMD_FINALIZE = 3'd2;
    localparam logic [2:0] CMD_BOOT     = 3'd3;
    localparam logic [2:0] CMD_CONFIRM  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_BAD_SIG    = 3'd2;
    localparam logic [2:0] ST_VERSION    = 3'd3;
    localparam logic [2:0] ST_HW         = 3'd4;
    localparam logic [2:0] ST_WRITE_FAIL = 3'd5;

    // input item payload, first field in the highest bits
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] expected_crc;
        logic [23:0] image_bytes;
        logic [7:0]  hw_rev_max;
        logic [7:0]  hw_rev_min;
        logic [7:0]  ver_patch;
        logic [7:0]  ver_minor;
        logic [15:0] ver_major;
    } in_item_t;

    // result item payload, first field in the highest bits
    typedef struct packed {
        logic [3:0]  attempt_count;
        logic [7:0]  write_value;
        logic [17:0] write_address;
        logic        write_target;
        logic        write_enable;
        logic        erase_request;
        logic        boot_bank;
        logic [2:0]  update_state;
        logic [2:0]  status;
    } result_t;

    // reflected crc-32 over one byte, eight bit steps
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/ab_bank_update_controller.sv -----
// a/b bank update controller: version and hardware checks, download with crc-32,
// boot attempt counting and rollback; depends on abuc_pkg
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tuser cmd, s_tdata version, range, size, crc, byte
//  m_*       out  m_tvalid / m_tready  m_tdata one result item per input item
//  cfg_*     in   cfg_we               cfg_index, cfg_data (no read-back)
//
// one item per cycle sustained while m_tready holds; an item waits in the input register, its
// result is computed by the crc byte step and compares in front of the result register
// and shows on m_* the cycle after it leaves the input register.
// reset sets all control, state and configuration to defaults, including the running crc to all ones;
// the input payload is not reset. a stalled result holds the result register; the input register still takes one item.
module ab_bank_update_controller
    import abuc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ver_major, ver_minor, ver_patch, hw_rev_min, hw_rev_max, image_bytes,
    // expected_crc, data_byte
    input  logic [111:0] s_tdata,
    // cmd
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, update_state, boot_bank, erase_request, write_enable, write_target,
    // write_address, write_value, attempt_count
    output logic [39:0]  m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DOWNLOAD = 3'd1,
        PH_VERIFY   = 3'd2,
        PH_PENDING  = 3'd3,
        PH_TESTING  = 3'd4,
        PH_COMPLETE = 3'd5,
        PH_ROLLBACK = 3'd6
    } phase_t;

    // input register
    logic       in_valid_reg;
    logic [2:0] in_cmd_reg;
    in_item_t   in_item_reg;

    // result register
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;

    // configuration
    logic [7:0] hw_revision_reg;
    logic [3:0] max_attempts_reg;

    // controller state
    phase_t            phase_reg, phase_next;
    logic              run_bank_reg, run_bank_next;
    logic              target_bank_reg, target_bank_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [CNT_W-1:0]  image_length_reg, image_length_next;
    logic [31:0]       crc_reg, crc_next;
    logic [3:0]        tries_reg, tries_next;
    logic [31:0]       floor_reg, floor_next;
    logic [31:0]       installed_reg, installed_next;
    logic [31:0]       pending_reg, pending_next;

    logic out_free;
    logic fire;
    logic in_take;

    // handshake: the result register frees when empty or taken
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // command decode and state update for the item in the input register
    always_comb
    begin
        logic [31:0] ver;
        logic [2:0]  status;
        logic        erase;
        logic        wen;
        logic [17:0] waddr;
        logic [7:0]  wval;
        ver    = {in_item_reg.ver_major, in_item_reg.ver_minor, in_item_reg.ver_patch};
        status = ST_OK;
        erase  = 1'b0;
        wen    = 1'b0;
        waddr  = '0;
        wval   = '0;

        phase_next        = phase_reg;
        run_bank_next     = run_bank_reg;
        target_bank_next  = target_bank_reg;
        byte_count_next   = byte_count_reg;
        image_length_next = image_length_reg;
        crc_next          = crc_reg;
        tries_next        = tries_reg;
        floor_next        = floor_reg;
        installed_next    = installed_reg;
        pending_next      = pending_reg;

        case (in_cmd_reg)
            CMD_START:
            begin
                if (ver < floor_reg || ver < installed_reg) begin
                    status = ST_VERSION;
                end else if (hw_revision_reg < in_item_reg.hw_rev_min
                             || hw_revision_reg > in_item_reg.hw_rev_max) begin
                    status = ST_HW;
                end else if ({1'b0, in_item_reg.image_bytes} > 25'(BANK_BYTES)) begin
                    status = ST_NO_SPACE;
                end else begin
                    phase_next        = PH_DOWNLOAD;
                    byte_count_next   = '0;
                    image_length_next = CNT_W'(in_item_reg.image_bytes);
                    target_bank_next  = !run_bank_reg;
                    crc_next          = CRC_INIT;
                    pending_next      = ver;
                    erase             = 1'b1;
                end
            end
            CMD_DATA:
            begin
                if (phase_reg != PH_DOWNLOAD || byte_count_reg >= CNT_W'(BANK_BYTES)) begin
                    status = ST_WRITE_FAIL;
                end else begin
                    wen   = 1'b1;
                    waddr = 18'(byte_count_reg);
                    wval  = in_item_reg.data_byte;
                    if (byte_count_reg < image_length_reg) begin
                        crc_next = crc_fold(crc_reg, in_item_reg.data_byte);
                    end
                    byte_count_next = byte_count_reg + 1'b1;
                end
            end
            CMD_FINALIZE:
            begin
                if (phase_reg != PH_DOWNLOAD) begin
                    status = ST_WRITE_FAIL;
                end else if (byte_count_reg < image_length_reg
                             || (crc_reg ^ CRC_INIT) != in_item_reg.expected_crc) begin
                    status     = ST_BAD_SIG;
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_PENDING;
                    tries_next = '0;
                end
            end
            CMD_BOOT:
            begin
                if (phase_reg == PH_PENDING) begin
                    phase_next    = PH_TESTING;
                    run_bank_next = target_bank_reg;
                    if (tries_reg < TRIES_MAX) begin
                        tries_next = tries_reg + 1'b1;
                    end
                end else if (phase_reg == PH_TESTING) begin
                    if (tries_reg >= max_attempts_reg) begin
                        phase_next    = PH_ROLLBACK;
                        run_bank_next = !target_bank_reg;
                    end else if (tries_reg < TRIES_MAX) begin
                        tries_next = tries_reg + 1'b1;
                    end
                end
            end
            CMD_CONFIRM:
            begin
                if (phase_reg == PH_TESTING) begin
                    phase_next     = PH_COMPLETE;
                    installed_next = pending_reg;
                    floor_next     = pending_reg;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        result_next.status        = status;
        result_next.update_state  = phase_next;
        result_next.boot_bank     = run_bank_next;
        result_next.erase_request = erase;
        result_next.write_enable  = wen;
        result_next.write_target  = target_bank_next;
        result_next.write_address = waddr;
        result_next.write_value   = wval;
        result_next.attempt_count = tries_next;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_cmd_reg  <= s_tuser;
            in_item_reg <= in_item_t'(s_tdata);
        end
    end

    // state, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            result_reg       <= '0;
            hw_revision_reg  <= 8'd1;
            max_attempts_reg <= 4'd3;
            phase_reg        <= PH_IDLE;
            run_bank_reg     <= 1'b0;
            target_bank_reg  <= 1'b0;
            byte_count_reg   <= '0;
            image_length_reg <= '0;
            crc_reg          <= CRC_INIT;
            tries_reg        <= '0;
            floor_reg        <= '0;
            installed_reg    <= VER_INIT;
            pending_reg      <= '0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                out_valid_reg    <= 1'b1;
                result_reg       <= result_next;
                phase_reg        <= phase_next;
                run_bank_reg     <= run_bank_next;
                target_bank_reg  <= target_bank_next;
                byte_count_reg   <= byte_count_next;
                image_length_reg <= image_length_next;
                crc_reg          <= crc_next;
                tries_reg        <= tries_next;
                floor_reg        <= floor_next;
                installed_reg    <= installed_next;
                pending_reg      <= pending_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_HW_REVISION:  hw_revision_reg  <= cfg_data;
                    CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[3:0];
                    default:          hw_revision_reg  <= hw_revision_reg;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // an erase request only comes with an accepted start
    a_erase_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.erase_request) |->
            (result_reg.status == ST_OK && result_reg.update_state == PH_DOWNLOAD))
        else $error("erase request without accepted start");

    // a flash write is only issued while downloading
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.write_enable) |->
            (result_reg.status == ST_OK && result_reg.update_state == PH_DOWNLOAD))
        else $error("flash write outside download");

    // full input register behind a stalled result blocks new items
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both registers are held");

    // testing runs the new bank, rollback runs the other one
    a_test_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TESTING) |-> (run_bank_reg == target_bank_reg))
        else $error("testing phase not on target bank");

    a_rollback_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ROLLBACK) |-> (run_bank_reg != target_bank_reg))
        else $error("rollback phase still on target bank");
`endif

endmodule
